// ===== src/gcb_pkg.sv =====
// Shared types, codes and helpers for the grid cell binning block.
// Used by gcb_cfg, gcb_ctrl, gcb_dpath and grid_cell_binning.
package gcb_pkg;

    localparam int DEF_MAX_CELLS      = 256;
    localparam int DEF_SLOTS_PER_CELL = 16;

    localparam int ID_W     = 10;
    localparam int POS_W    = 24;
    localparam int WIDTH_W  = 23;
    localparam int CELLS_W  = 9;
    localparam int CIDX_W   = 8;
    localparam int SLOT_W   = 4;
    localparam int STAT_W   = 2;
    localparam int WR_IDX_W = 3;
    localparam int WR_DAT_W = 24;

    localparam int DIV_STEPS  = POS_W;
    localparam int DSTEP_W    = $clog2(DIV_STEPS);
    localparam int PROD_W     = 2 * CELLS_W;
    localparam int SUM_W      = PROD_W + 1;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    typedef enum logic [STAT_W-1:0] {
        STATUS_STORED  = 2'd0,
        STATUS_OUTSIDE = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef enum logic [WR_IDX_W-1:0] {
        REG_BOX_LEFT     = 3'd0,
        REG_BOX_TOP      = 3'd1,
        REG_CELL_WIDTH   = 3'd2,
        REG_CELLS_ACROSS = 3'd3,
        REG_CELLS_DOWN   = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FCLEAR,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_INDEX,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] box_left;
        logic signed [POS_W-1:0] box_top;
        logic [WIDTH_W-1:0]      cell_width;
        logic [CELLS_W-1:0]      cells_across;
        logic [CELLS_W-1:0]      cells_down;
    } cfg_t;

    typedef struct packed {
        logic latch_in;
        logic clr_step;
        logic prep;
        logic div_step;
        logic mul;
        logic index;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic early_reject;
        logic div_last;
        logic cell_bad;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] rem;
        logic [POS_W-1:0]   quo;
    } div_t;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic div_t div_step(div_t cur, logic [WIDTH_W-1:0] d);
        logic [WIDTH_W:0] trial;
        div_t             nxt;
        trial   = {cur.rem, cur.quo[POS_W-1]};
        nxt.quo = {cur.quo[POS_W-2:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            nxt.rem    = WIDTH_W'(trial - {1'b0, d});
            nxt.quo[0] = 1'b1;
        end
        else
        begin
            nxt.rem = trial[WIDTH_W-1:0];
        end
        return nxt;
    endfunction

endpackage

// ===== src/gcb_cfg.sv =====
// Configuration register file for the grid cell binning block.
// Depends on gcb_pkg for the register index codes and cfg_t.
module gcb_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [gcb_pkg::WR_IDX_W-1:0]  wr_index,
    input  logic [gcb_pkg::WR_DAT_W-1:0]  wr_data,
    output gcb_pkg::cfg_t                 cfg
);

    gcb_pkg::cfg_t cfg_reg;
    gcb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                gcb_pkg::REG_BOX_LEFT:     cfg_next.box_left     = wr_data;
                gcb_pkg::REG_BOX_TOP:      cfg_next.box_top      = wr_data;
                gcb_pkg::REG_CELL_WIDTH:
                    cfg_next.cell_width   = wr_data[gcb_pkg::WIDTH_W-1:0];
                gcb_pkg::REG_CELLS_ACROSS:
                    cfg_next.cells_across = wr_data[gcb_pkg::CELLS_W-1:0];
                gcb_pkg::REG_CELLS_DOWN:
                    cfg_next.cells_down   = wr_data[gcb_pkg::CELLS_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_left     <= '0;
            cfg_reg.box_top      <= '0;
            cfg_reg.cell_width   <= gcb_pkg::WIDTH_W'(256);
            cfg_reg.cells_across <= gcb_pkg::CELLS_W'(16);
            cfg_reg.cells_down   <= gcb_pkg::CELLS_W'(16);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/gcb_ctrl.sv =====
// Sequencer for the grid cell binning block: clear sweeps, division, lookup, update.
// Depends on gcb_pkg for state_t, cmd_t and sts_t.
module gcb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           new_frame,
    output logic           s_tready,
    input  gcb_pkg::sts_t  sts,
    output gcb_pkg::cmd_t  cmd
);

    gcb_pkg::state_t state_reg;
    gcb_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gcb_pkg::ST_CLEAR:
                if (sts.clr_last) state_next = gcb_pkg::ST_IDLE;
            gcb_pkg::ST_IDLE:
                if (s_tvalid)
                    state_next = new_frame ? gcb_pkg::ST_FCLEAR : gcb_pkg::ST_PREP;
            gcb_pkg::ST_FCLEAR:
                if (sts.clr_last) state_next = gcb_pkg::ST_PREP;
            gcb_pkg::ST_PREP:
                state_next = sts.early_reject ? gcb_pkg::ST_DONE : gcb_pkg::ST_DIV;
            gcb_pkg::ST_DIV:
                if (sts.div_last) state_next = gcb_pkg::ST_MUL;
            gcb_pkg::ST_MUL:
                state_next = gcb_pkg::ST_INDEX;
            gcb_pkg::ST_INDEX:
                state_next = sts.cell_bad ? gcb_pkg::ST_DONE : gcb_pkg::ST_UPDATE;
            gcb_pkg::ST_UPDATE:
                state_next = gcb_pkg::ST_DONE;
            gcb_pkg::ST_DONE:
                if (sts.out_free) state_next = gcb_pkg::ST_IDLE;
            default:
                state_next = gcb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            gcb_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
            gcb_pkg::ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            gcb_pkg::ST_FCLEAR: cmd.clr_step = 1'b1;
            gcb_pkg::ST_PREP:   cmd.prep     = 1'b1;
            gcb_pkg::ST_DIV:    cmd.div_step = 1'b1;
            gcb_pkg::ST_MUL:    cmd.mul      = 1'b1;
            gcb_pkg::ST_INDEX:  cmd.index    = 1'b1;
            gcb_pkg::ST_UPDATE: cmd.update   = 1'b1;
            gcb_pkg::ST_DONE:   cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gcb_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/gcb_dpath.sv =====
// Datapath for the grid cell binning block: offsets, two restoring dividers,
// cell index, count memory, member memory and output register. Depends on gcb_pkg.
module gcb_dpath #(
    parameter int MAX_CELLS      = gcb_pkg::DEF_MAX_CELLS,
    parameter int SLOTS_PER_CELL = gcb_pkg::DEF_SLOTS_PER_CELL
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gcb_pkg::cfg_t                   cfg,
    input  gcb_pkg::cmd_t                   cmd,
    output gcb_pkg::sts_t                   sts,
    input  logic [gcb_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gcb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [gcb_pkg::STAT_W-1:0]      m_tuser
);

    localparam int CELL_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int SLOT_AW = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int CNT_W   = $clog2(SLOTS_PER_CELL + 1);
    localparam int DIFF_W  = gcb_pkg::POS_W + 1;

    // input fields
    logic [gcb_pkg::ID_W-1:0]         in_id;
    logic signed [gcb_pkg::POS_W-1:0] in_x;
    logic signed [gcb_pkg::POS_W-1:0] in_y;

    logic [gcb_pkg::ID_W-1:0] id_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;

    gcb_pkg::div_t              xdiv_reg, xdiv_next;
    gcb_pkg::div_t              ydiv_reg, ydiv_next;
    logic [gcb_pkg::DSTEP_W-1:0] step_reg, step_next;

    logic                        range_bad_reg;
    logic [gcb_pkg::PROD_W-1:0]  prod_reg;
    logic [gcb_pkg::SUM_W-1:0]   sum;
    logic [CELL_AW-1:0]          cell_reg;
    logic [gcb_pkg::CIDX_W-1:0]  cidx_reg;
    logic [CNT_W-1:0]            cnt_rd_reg;
    logic                        full;

    logic [CELL_AW-1:0] clr_reg, clr_next;

    logic [gcb_pkg::CIDX_W-1:0] res_cell_reg;
    logic [gcb_pkg::SLOT_W-1:0] res_slot_reg;
    gcb_pkg::status_t           res_status_reg;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [gcb_pkg::CIDX_W-1:0] m_cell_reg;
    logic [gcb_pkg::SLOT_W-1:0] m_slot_reg;
    gcb_pkg::status_t           m_status_reg;

    logic [CNT_W-1:0]         cell_counts [MAX_CELLS];
    logic [gcb_pkg::ID_W-1:0] cell_members [MAX_CELLS][SLOTS_PER_CELL];

    assign in_id = s_tdata[gcb_pkg::ID_W-1:0];
    assign in_x  = s_tdata[gcb_pkg::ID_W +: gcb_pkg::POS_W];
    assign in_y  = s_tdata[gcb_pkg::ID_W + gcb_pkg::POS_W +: gcb_pkg::POS_W];

    assign sum  = {{(gcb_pkg::SUM_W - gcb_pkg::CELLS_W){1'b0}},
                   xdiv_reg.quo[gcb_pkg::CELLS_W-1:0]}
                + {1'b0, prod_reg};
    assign full = (cnt_rd_reg >= CNT_W'(SLOTS_PER_CELL));

    always_comb
    begin
        sts.clr_last     = (clr_reg == CELL_AW'(MAX_CELLS - 1));
        sts.early_reject = (cfg.cell_width == '0) || dx_reg[DIFF_W-1] || dy_reg[DIFF_W-1];
        sts.div_last     = (step_reg == gcb_pkg::DSTEP_W'(gcb_pkg::DIV_STEPS - 1));
        sts.cell_bad     = range_bad_reg || (sum >= gcb_pkg::SUM_W'(MAX_CELLS));
        sts.out_free     = !m_tvalid_reg || m_tready;
    end

    // divider and sweep counters
    always_comb
    begin
        xdiv_next = xdiv_reg;
        ydiv_next = ydiv_reg;
        step_next = step_reg;
        clr_next  = clr_reg;
        if (cmd.prep)
        begin
            xdiv_next.rem = '0;
            xdiv_next.quo = dx_reg[gcb_pkg::POS_W-1:0];
            ydiv_next.rem = '0;
            ydiv_next.quo = dy_reg[gcb_pkg::POS_W-1:0];
            step_next     = '0;
        end
        else if (cmd.div_step)
        begin
            xdiv_next = gcb_pkg::div_step(xdiv_reg, cfg.cell_width);
            ydiv_next = gcb_pkg::div_step(ydiv_reg, cfg.cell_width);
            step_next = step_reg + 1'b1;
        end
        if (cmd.clr_step)
            clr_next = sts.clr_last ? '0 : CELL_AW'(clr_reg + 1'b1);
        m_tvalid_next = cmd.out_load ? 1'b1 : (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xdiv_reg <= xdiv_next;
        ydiv_reg <= ydiv_next;
        if (cmd.latch_in)
        begin
            id_reg <= in_id;
            dx_reg <= DIFF_W'(in_x) - DIFF_W'(cfg.box_left);
            dy_reg <= DIFF_W'(cfg.box_top) - DIFF_W'(in_y);
        end
        if (cmd.mul)
        begin
            range_bad_reg <=
                (xdiv_reg.quo >= gcb_pkg::POS_W'(cfg.cells_across)) ||
                (ydiv_reg.quo >= gcb_pkg::POS_W'(cfg.cells_down));
            prod_reg <= gcb_pkg::CELLS_W'(ydiv_reg.quo) * cfg.cells_across;
        end
        if (cmd.index)
        begin
            cell_reg <= sum[CELL_AW-1:0];
            cidx_reg <= sum[gcb_pkg::CIDX_W-1:0];
        end
        // rejected unless a later step finds the cell
        if (cmd.prep)
        begin
            res_cell_reg   <= '0;
            res_slot_reg   <= '0;
            res_status_reg <= gcb_pkg::STATUS_OUTSIDE;
        end
        else if (cmd.update)
        begin
            if (full)
            begin
                res_status_reg <= gcb_pkg::STATUS_FULL;
            end
            else
            begin
                res_cell_reg   <= cidx_reg;
                res_slot_reg   <= gcb_pkg::SLOT_W'(cnt_rd_reg);
                res_status_reg <= gcb_pkg::STATUS_STORED;
            end
        end
        if (cmd.out_load)
        begin
            m_cell_reg   <= res_cell_reg;
            m_slot_reg   <= res_slot_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // count memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            cell_counts[clr_reg] <= '0;
        else if (cmd.update && !full)
            cell_counts[cell_reg] <= CNT_W'(cnt_rd_reg + 1'b1);
        if (cmd.index)
            cnt_rd_reg <= cell_counts[sum[CELL_AW-1:0]];
    end

    // member memory: write only
    always_ff @(posedge clk)
    begin
        if (cmd.update && !full)
            cell_members[cell_reg][cnt_rd_reg[SLOT_AW-1:0]] <= id_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(gcb_pkg::M_TDATA_W - gcb_pkg::CIDX_W - gcb_pkg::SLOT_W){1'b0}},
                       m_slot_reg, m_cell_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== src/grid_cell_binning.sv =====
// Top level of the grid cell binning block: uniform grid spatial hash.
// Depends on gcb_pkg, gcb_cfg, gcb_ctrl and gcb_dpath.
//
// Each input word bins one particle into a uniform grid laid over a box whose
// upper-left corner is (box_left, box_top); rows grow downward. One result word
// comes back per input word: cell index, slot written, and a status (stored,
// outside the box, cell full). One item at a time: an accepted word goes through
// accept, setup, 24 steps of the two restoring dividers by cell_width running
// side by side, the row times cells_across product, index and count read, count
// update and output load before the next accept. A word rejected at setup skips
// the divide; one that lands outside the grid after the divide skips the update.
// A word with new_frame set first sweeps the count memory, one cell a cycle.
// After reset the same clearing pass runs with s_tready low; configuration
// writes are taken at any time. A finished result waits in the output register
// while the next word is accepted.
module grid_cell_binning #(
    parameter int MAX_CELLS      = gcb_pkg::DEF_MAX_CELLS,
    parameter int SLOTS_PER_CELL = gcb_pkg::DEF_SLOTS_PER_CELL
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [9:0] particle_id, [33:10] pos_x, [57:34] pos_y, [63:58] zero
    input  logic [gcb_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] new_frame
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] cell_index, [11:8] slot, [15:12] zero
    output logic [gcb_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [gcb_pkg::STAT_W-1:0]     m_tuser,
    input  logic                           wr_en,
    input  logic [gcb_pkg::WR_IDX_W-1:0]   wr_index,
    input  logic [gcb_pkg::WR_DAT_W-1:0]   wr_data
);

    gcb_pkg::cfg_t cfg;
    gcb_pkg::cmd_t cmd;
    gcb_pkg::sts_t sts;

    gcb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    gcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .new_frame (s_tuser[0]),
        .s_tready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gcb_dpath #(
        .MAX_CELLS      (MAX_CELLS),
        .SLOTS_PER_CELL (SLOTS_PER_CELL)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== dv/tb.sv =====
// Testbench for grid_cell_binning: drives particle words, predicts each cell bin
// in a local model of the grid, and checks every result word in order.
// Depends on gcb_pkg and the grid_cell_binning RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    MAX_CELLS    = gcb_pkg::DEF_MAX_CELLS;
    localparam int    SLOTS        = gcb_pkg::DEF_SLOTS_PER_CELL;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    IDLE_TAIL    = 40;
    localparam int    LIMIT_CYCLES = 1000000;
    localparam int    POS_MIN      = -8388608;
    localparam int    POS_MAX      = 8388607;

    localparam int RX_ALWAYS = 0;
    localparam int RX_CHOPPY = 1;
    localparam int RX_SLOW   = 2;

    typedef struct {
        logic [gcb_pkg::ID_W-1:0]         id;
        logic signed [gcb_pkg::POS_W-1:0] x;
        logic signed [gcb_pkg::POS_W-1:0] y;
        logic                             new_frame;
    } particle_t;

    typedef struct {
        logic [gcb_pkg::CIDX_W-1:0] cell_index;
        logic [gcb_pkg::SLOT_W-1:0] slot;
        gcb_pkg::status_t           status;
    } bin_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [gcb_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [0:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [gcb_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [gcb_pkg::STAT_W-1:0]     m_tuser;
    logic                           wr_en;
    logic [gcb_pkg::WR_IDX_W-1:0]   wr_index;
    logic [gcb_pkg::WR_DAT_W-1:0]   wr_data;

    // local copy of the grid configuration and the per-cell fill counts
    logic signed [gcb_pkg::POS_W-1:0] cfg_left   = '0;
    logic signed [gcb_pkg::POS_W-1:0] cfg_top    = '0;
    logic [gcb_pkg::WIDTH_W-1:0]      cfg_width  = 23'd256;
    logic [gcb_pkg::CELLS_W-1:0]      cfg_across = 9'd16;
    logic [gcb_pkg::CELLS_W-1:0]      cfg_down   = 9'd16;
    int                               cell_fill[MAX_CELLS];

    bin_result_t pending_bins[$];
    int          err_count  = 0;
    int          burst_left = 0;
    bit          gaps_on    = 1'b1;
    int          rx_mode    = RX_ALWAYS;
    int          hold_reqs  = 0;
    int          cycle_count = 0;

    grid_cell_binning uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        foreach (cell_fill[i])
            cell_fill[i] = 0;
    end

    function automatic bin_result_t predict_bin(particle_t p);
        bin_result_t r;
        longint      dx;
        longint      dy;
        longint      col;
        longint      row;
        longint      cell_no;
        r.cell_index = '0;
        r.slot       = '0;
        r.status     = gcb_pkg::STATUS_OUTSIDE;
        // the frame clear applies even when the particle itself is rejected
        if (p.new_frame)
            foreach (cell_fill[i])
                cell_fill[i] = 0;
        dx = longint'(p.x) - longint'(cfg_left);
        dy = longint'(cfg_top) - longint'(p.y);
        if (cfg_width == 0 || dx < 0 || dy < 0)
            return r;
        col = dx / longint'(cfg_width);
        row = dy / longint'(cfg_width);
        if (col >= longint'(cfg_across) || row >= longint'(cfg_down))
            return r;
        cell_no = col + row * longint'(cfg_across);
        if (cell_no >= longint'(MAX_CELLS))
            return r;
        if (cell_fill[cell_no] >= SLOTS)
        begin
            r.status = gcb_pkg::STATUS_FULL;
            return r;
        end
        r.cell_index = cell_no[gcb_pkg::CIDX_W-1:0];
        r.slot       = cell_fill[cell_no][gcb_pkg::SLOT_W-1:0];
        r.status     = gcb_pkg::STATUS_STORED;
        cell_fill[cell_no]++;
        return r;
    endfunction

    function automatic particle_t particle(int id, int x, int y, bit nf);
        particle_t p;
        p.id        = id[gcb_pkg::ID_W-1:0];
        p.x         = x[gcb_pkg::POS_W-1:0];
        p.y         = y[gcb_pkg::POS_W-1:0];
        p.new_frame = nf;
        return p;
    endfunction

    // Mostly aim at real cells (a hot pair of cells fills up), the rest is noise.
    function automatic particle_t make_particle(int frame_one_in);
        particle_t p;
        longint    w;
        longint    col;
        longint    row;
        longint    x;
        longint    y;
        p.id        = gcb_pkg::ID_W'($urandom);
        p.new_frame = ($urandom_range(frame_one_in - 1) == 0);
        p.x         = gcb_pkg::POS_W'($urandom);
        p.y         = gcb_pkg::POS_W'($urandom);
        w = longint'(cfg_width);
        if (w != 0 && $urandom_range(99) >= 20)
        begin
            if ($urandom_range(1))
            begin
                col = longint'($urandom_range(1));
                row = 0;
            end
            else
            begin
                col = longint'($urandom_range(cfg_across));
                row = longint'($urandom_range(cfg_down));
            end
            x = longint'(cfg_left) + col * w + longint'($urandom_range(int'(w - 1)));
            y = longint'(cfg_top) - row * w - longint'($urandom_range(int'(w - 1)));
            if (x >= longint'(POS_MIN) && x <= longint'(POS_MAX) &&
                y >= longint'(POS_MIN) && y <= longint'(POS_MAX))
            begin
                p.x = x[gcb_pkg::POS_W-1:0];
                p.y = y[gcb_pkg::POS_W-1:0];
            end
        end
        return p;
    endfunction

    task automatic send_particle(input particle_t p);
        int gap;
        if (gaps_on && burst_left <= 0)
        begin
            gap        = $urandom_range(1, 15);
            burst_left = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, p.y, p.x, p.id};
        s_tuser  <= p.new_frame;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
    endtask

    // Drop valid and wait until every predicted bin has come back.
    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_bins.size() != 0)
            @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gcb_pkg::WR_IDX_W-1:0] idx,
                             input logic [gcb_pkg::WR_DAT_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            gcb_pkg::REG_BOX_LEFT:     cfg_left   = data;
            gcb_pkg::REG_BOX_TOP:      cfg_top    = data;
            gcb_pkg::REG_CELL_WIDTH:   cfg_width  = data[gcb_pkg::WIDTH_W-1:0];
            gcb_pkg::REG_CELLS_ACROSS: cfg_across = data[gcb_pkg::CELLS_W-1:0];
            gcb_pkg::REG_CELLS_DOWN:   cfg_down   = data[gcb_pkg::CELLS_W-1:0];
            default:                   ;
        endcase
    endtask

    task automatic test_bounds();
        rx_mode = RX_CHOPPY;
        gaps_on = 1'b1;
        send_particle(particle(0, 0, 0, 1'b1));
        send_particle(particle(1023, 4095, -4095, 1'b0));
        send_particle(particle(1, -1, 0, 1'b0));
        send_particle(particle(2, 0, 1, 1'b0));
        send_particle(particle(3, 4096, 0, 1'b0));
        send_particle(particle(4, 0, -4096, 1'b0));
        send_particle(particle(5, POS_MIN, POS_MAX, 1'b0));
        send_particle(particle(6, POS_MAX, POS_MIN, 1'b1));
    endtask

    task automatic test_full_cell();
        for (int k = 0; k < SLOTS + 1; k++)
            send_particle(particle($urandom, 5 * 256 + k * 15, -k * 15, 1'b0));
        // a new frame empties the cell again
        send_particle(particle($urandom, 5 * 256, 0, 1'b1));
    endtask

    task automatic test_grid_limits();
        wait_idle();
        write_reg(gcb_pkg::REG_CELL_WIDTH, gcb_pkg::WR_DAT_W'(0));
        send_particle(particle(7, 10, -10, 1'b0));
        wait_idle();
        write_reg(gcb_pkg::REG_CELL_WIDTH, gcb_pkg::WR_DAT_W'(256));
        write_reg(gcb_pkg::REG_CELLS_ACROSS, gcb_pkg::WR_DAT_W'(0));
        send_particle(particle(8, 10, -10, 1'b0));
        wait_idle();
        // 32 x 16 grid runs past the cell store
        write_reg(gcb_pkg::REG_CELLS_ACROSS, gcb_pkg::WR_DAT_W'(32));
        send_particle(particle(9, 10, -8 * 256 - 10, 1'b0));
        send_particle(particle(10, 31 * 256 + 10, -7 * 256 - 10, 1'b0));
        wait_idle();
        write_reg(gcb_pkg::REG_CELLS_ACROSS, gcb_pkg::WR_DAT_W'(16));
        write_reg(gcb_pkg::REG_CELLS_DOWN, gcb_pkg::WR_DAT_W'(0));
        send_particle(particle(11, 10, -10, 1'b0));
        wait_idle();
        write_reg(gcb_pkg::REG_CELLS_DOWN, gcb_pkg::WR_DAT_W'(16));
        // writes past the last register are dropped
        for (int i = int'(gcb_pkg::REG_CELLS_DOWN) + 1; i < (1 << gcb_pkg::WR_IDX_W); i++)
            write_reg(gcb_pkg::WR_IDX_W'(i), gcb_pkg::WR_DAT_W'($urandom));
        send_particle(particle(12, 10, -10, 1'b0));
    endtask

    task automatic test_backpressure();
        wait_idle();
        rx_mode   = RX_ALWAYS;
        gaps_on   = 1'b0;
        hold_reqs = hold_reqs + 1;
        repeat (12) send_particle(make_particle(100));
    endtask

    task automatic run_phase(input logic [gcb_pkg::WR_DAT_W-1:0] left,
                             input logic [gcb_pkg::WR_DAT_W-1:0] top,
                             input logic [gcb_pkg::WR_DAT_W-1:0] width,
                             input int across, input int down,
                             input int count, input int mode, input bit gaps);
        wait_idle();
        write_reg(gcb_pkg::REG_BOX_LEFT, left);
        write_reg(gcb_pkg::REG_BOX_TOP, top);
        write_reg(gcb_pkg::REG_CELL_WIDTH, width);
        write_reg(gcb_pkg::REG_CELLS_ACROSS, gcb_pkg::WR_DAT_W'(across));
        write_reg(gcb_pkg::REG_CELLS_DOWN, gcb_pkg::WR_DAT_W'(down));
        rx_mode = mode;
        gaps_on = gaps;
        repeat (count) send_particle(make_particle(100));
    endtask

    task automatic test_random_sweep();
        run_phase(gcb_pkg::WR_DAT_W'($urandom_range(4000) - 2000),
                  gcb_pkg::WR_DAT_W'($urandom_range(4000) - 2000),
                  gcb_pkg::WR_DAT_W'(256), 4, 4, 100, RX_CHOPPY, 1'b1);
        run_phase(gcb_pkg::WR_DAT_W'($urandom), gcb_pkg::WR_DAT_W'($urandom),
                  gcb_pkg::WR_DAT_W'($urandom_range(1, 65535)), $urandom_range(1, 256),
                  $urandom_range(1, 256), 100, RX_SLOW, 1'b1);
        run_phase(gcb_pkg::WR_DAT_W'(POS_MAX - 600), gcb_pkg::WR_DAT_W'(POS_MIN + 600),
                  gcb_pkg::WR_DAT_W'(1), 511, 511, 100, RX_ALWAYS, 1'b0);
        run_phase(24'h800000, 24'h7fffff, 24'hffffff, 511, 511, 100, RX_CHOPPY, 1'b0);
        run_phase(gcb_pkg::WR_DAT_W'(0), gcb_pkg::WR_DAT_W'(0), gcb_pkg::WR_DAT_W'(16),
                  256, 1, 100, RX_ALWAYS, 1'b1);
        run_phase(gcb_pkg::WR_DAT_W'($urandom), gcb_pkg::WR_DAT_W'($urandom),
                  gcb_pkg::WR_DAT_W'(3), 1, 256, 100, RX_SLOW, 1'b1);
    endtask

    // Result sink: always ready or alternating ready/stall runs by rx_mode, plus an occasional long hold-off.
    initial
    begin : rx_pattern
        int   run_len;
        int   hold_cnt;
        int   holds_seen;
        logic level;
        level      = 1'b1;
        run_len    = 0;
        holds_seen = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_seen)
            begin
                holds_seen = hold_reqs;
                m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
                run_len  = 0;
            end
            else if (rx_mode == RX_ALWAYS)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                if (run_len <= 0)
                begin
                    level = !level;
                    if (rx_mode == RX_CHOPPY)
                        run_len = level ? $urandom_range(1, 6) : $urandom_range(1, 4);
                    else
                        run_len = level ? $urandom_range(1, 20) : $urandom_range(1, 12);
                end
                m_tready <= level;
                run_len--;
            end
        end
    end

    always @(posedge clk)
    begin : accept_mon
        particle_t p;
        if (rst_n && s_tvalid && s_tready)
        begin
            p.id        = s_tdata[9:0];
            p.x         = s_tdata[33:10];
            p.y         = s_tdata[57:34];
            p.new_frame = s_tuser[0];
            pending_bins.push_back(predict_bin(p));
        end
    end

    always @(posedge clk)
    begin : result_mon
        bin_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bins.size() == 0)
            begin
                $display("%0t: unexpected result word, actual cell %0d slot %0d status %0d",
                         $time, m_tdata[7:0], m_tdata[11:8], m_tuser);
                err_count++;
            end
            else
            begin
                exp_r = pending_bins.pop_front();
                if (m_tdata[7:0] !== exp_r.cell_index)
                begin
                    $display("%0t: cell_index mismatch, expected %0d actual %0d",
                             $time, exp_r.cell_index, m_tdata[7:0]);
                    err_count++;
                end
                if (m_tdata[11:8] !== exp_r.slot)
                begin
                    $display("%0t: slot mismatch, expected %0d actual %0d",
                             $time, exp_r.slot, m_tdata[11:8]);
                    err_count++;
                end
                if (m_tuser !== exp_r.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, exp_r.status, m_tuser);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        wr_en    <= 1'b0;
        wr_index <= '0;
        wr_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_bounds();
        test_full_cell();
        test_grid_limits();
        test_backpressure();
        test_random_sweep();
        wait_idle();

        if (pending_bins.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_bins.size());
            err_count++;
        end
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gcb_pkg.sv
src/gcb_cfg.sv
src/gcb_ctrl.sv
src/gcb_dpath.sv
src/grid_cell_binning.sv
dv/tb.sv
